// ===== design/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the box filter texture downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int MAX_DIM    = 8192;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = POS_W + 1;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int ACC_W      = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = DIM_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_MODE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(3);

    // size modes
    localparam logic [1:0] MODE_FULL   = 2'd0;
    localparam logic [1:0] MODE_MEDIUM = 2'd1;
    localparam logic [1:0] MODE_SMALL  = 2'd2;

    localparam logic [1:0]       RST_SIZE_MODE     = MODE_FULL;
    localparam logic [2:0]       RST_CHANNEL_COUNT = 3'd4;
    localparam logic [DIM_W-1:0] RST_SOURCE_DIM    = DIM_W'(1024);

    typedef struct packed {
        logic [CH_W-1:0] chan_a;
        logic [CH_W-1:0] chan_b;
        logic [CH_W-1:0] chan_c;
        logic [CH_W-1:0] chan_d;
    } in_pix_t;

    typedef struct packed {
        logic [CH_W-1:0]  mean_a;
        logic [CH_W-1:0]  mean_b;
        logic [CH_W-1:0]  mean_c;
        logic [CH_W-1:0]  mean_d;
        logic [POS_W-1:0] out_column;
        logic [POS_W-1:0] out_row;
        logic             image_done;
    } out_pix_t;

    // per-pixel control from the raster tracker to the accumulator stage
    typedef struct packed {
        logic [POS_W-1:0]  ox;
        logic [POS_W-1:0]  out_row;
        logic              first;
        logic              last;
        logic              done;
        logic [2:0]        shift;
        logic [NUM_CH-1:0] chan_en;
    } px_tag_t;

    typedef struct packed {
        logic a_vld;
        logic a_last;
    } acc_status_t;

endpackage

// ===== design/bfd_line_ram.sv =====
// ----------------------------------------------------------------------------
// bfd_line_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfd_line_ram #(
    parameter int DEPTH  = 8192,
    parameter int DATA_W = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bfd_raster.sv =====
// ----------------------------------------------------------------------------
// bfd_raster
// Configuration registers, reduction factors and source raster position.
// ----------------------------------------------------------------------------
module bfd_raster import bfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_fire,
    output px_tag_t               tag
);

    logic [1:0]       mode_reg;
    logic [2:0]       chcnt_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    logic [DIM_W-1:0] w, h;
    logic [1:0]       sx, sy;
    logic [1:0]       mx, my;
    logic [POS_W-1:0] col, row;
    logic [DIM_W-1:0] col_p1, row_p1;
    logic [2:0]       nch;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

    // log2 of the per-axis reduction factor
    function automatic logic [1:0] axis_shift(input logic [1:0] mode,
                                              input logic [DIM_W-1:0] d);
        logic [1:0] s;
        s = 2'd0;
        case (mode)
            MODE_SMALL:
            begin
                if (d > DIM_W'(256))
                    s = (d[1:0] == 2'b00) ? 2'd2 : 2'd0;
                else if (d > DIM_W'(128))
                    s = (d[0] == 1'b0) ? 2'd1 : 2'd0;
            end
            MODE_MEDIUM:
            begin
                if (d > DIM_W'(256) && d[0] == 1'b0)
                    s = 2'd1;
            end
            default:
            begin
                s = 2'd0;
            end
        endcase
        return s;
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        w   = clamp_dim(width_reg);
        h   = clamp_dim(height_reg);
        sx  = axis_shift(mode_reg, w);
        sy  = axis_shift(mode_reg, h);
        mx  = {sx[1], sx[1] | sx[0]};
        my  = {sy[1], sy[1] | sy[0]};
        col = ({1'b0, col_reg} < w) ? col_reg : '0;
        row = ({1'b0, row_reg} < h) ? row_reg : '0;

        if (chcnt_reg == 3'd0)
            nch = 3'd1;
        else if (chcnt_reg > 3'd4)
            nch = 3'd4;
        else
            nch = chcnt_reg;

        tag.ox      = col >> sx;
        tag.out_row = row >> sy;
        tag.first   = ((col[1:0] & mx) == 2'b00) && ((row[1:0] & my) == 2'b00);
        tag.last    = ((col[1:0] & mx) == mx) && ((row[1:0] & my) == my);
        tag.done    = ({1'b0, col} == w - DIM_W'(1)) && ({1'b0, row} == h - DIM_W'(1));
        tag.shift   = {1'b0, sx} + {1'b0, sy};
        for (int i = 0; i < NUM_CH; i++)
        begin
            tag.chan_en[i] = (3'(i) < nch);
        end

        // raster advance with wrap at end of line and end of image, restart on configuration write
        col_p1   = {1'b0, col} + DIM_W'(1);
        row_p1   = {1'b0, row} + DIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_valid && cfg_ready)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (col_p1 >= w)
            begin
                col_next = '0;
                row_next = (row_p1 >= h) ? '0 : row_p1[POS_W-1:0];
            end
            else
            begin
                col_next = col_p1[POS_W-1:0];
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RST_SIZE_MODE;
            chcnt_reg  <= RST_CHANNEL_COUNT;
            width_reg  <= RST_SOURCE_DIM;
            height_reg <= RST_SOURCE_DIM;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIZE_MODE:     mode_reg   <= cfg_data[1:0];
                    REG_CHANNEL_COUNT: chcnt_reg  <= cfg_data[2:0];
                    REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                    REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== design/bfd_accum.sv =====
// ----------------------------------------------------------------------------
// bfd_accum
// Block accumulation stage: line store read-modify-write and result register.
// ----------------------------------------------------------------------------
module bfd_accum import bfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_pix_t     in_data,
    input  px_tag_t     tag,
    output logic        out_valid,
    input  logic        out_ready,
    output out_pix_t    out_data,
    output acc_status_t status
);

    localparam int WORD_W = NUM_CH * ACC_W;

    logic                                a_vld_reg, a_vld_next;
    px_tag_t                             a_tag_reg;
    logic [NUM_CH-1:0][CH_W-1:0]         a_pix_reg;
    logic                                byp_hit_reg;
    logic [NUM_CH-1:0][ACC_W-1:0]        byp_data_reg;
    logic                                o_vld_reg, o_vld_next;
    out_pix_t                            o_data_reg;

    logic                                in_fire, adv;
    logic [NUM_CH-1:0][CH_W-1:0]         pix_in, pix_masked;
    logic [NUM_CH-1:0][ACC_W-1:0]        rd_data, base, sum;
    logic [NUM_CH-1:0][CH_W-1:0]         mean;
    out_pix_t                            o_data_next;

    bfd_line_ram #(
        .DEPTH  (MAX_DIM),
        .DATA_W (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (adv),
        .wr_addr (a_tag_reg.ox),
        .wr_data (sum),
        .rd_en   (in_fire),
        .rd_addr (tag.ox),
        .rd_data (rd_data)
    );

    // a block-final pixel needs the result slot, others retire freely
    assign adv      = a_vld_reg && (!a_tag_reg.last || !o_vld_reg || out_ready);
    assign in_ready = !a_vld_reg || adv;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        pix_in = {in_data.chan_a, in_data.chan_b, in_data.chan_c, in_data.chan_d};
        for (int i = 0; i < NUM_CH; i++)
        begin
            // channel 0 is chan_a, the top byte of the packed word
            pix_masked[i] = tag.chan_en[i] ? pix_in[NUM_CH-1-i] : '0;
        end

        // the entry written at the edge this pixel was read is not in rd_data yet
        base = byp_hit_reg ? byp_data_reg : rd_data;
        for (int i = 0; i < NUM_CH; i++)
        begin
            sum[i]  = a_tag_reg.first ? ACC_W'(a_pix_reg[i])
                                      : base[i] + ACC_W'(a_pix_reg[i]);
            mean[i] = CH_W'(sum[i] >> a_tag_reg.shift);
        end

        o_data_next.mean_a     = mean[0];
        o_data_next.mean_b     = mean[1];
        o_data_next.mean_c     = mean[2];
        o_data_next.mean_d     = mean[3];
        o_data_next.out_column = a_tag_reg.ox;
        o_data_next.out_row    = a_tag_reg.out_row;
        o_data_next.image_done = a_tag_reg.done;

        a_vld_next = in_fire ? 1'b1 : (adv ? 1'b0 : a_vld_reg);

        if (adv && a_tag_reg.last)
            o_vld_next = 1'b1;
        else if (out_ready)
            o_vld_next = 1'b0;
        else
            o_vld_next = o_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            o_vld_reg   <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            o_vld_reg <= o_vld_next;
            if (in_fire)
            begin
                byp_hit_reg <= adv && (a_tag_reg.ox == tag.ox);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_tag_reg    <= tag;
            a_pix_reg    <= pix_masked;
            byp_data_reg <= sum;
        end
        if (adv && a_tag_reg.last)
        begin
            o_data_reg <= o_data_next;
        end
    end

    assign out_valid     = o_vld_reg;
    assign out_data      = o_data_reg;
    assign status.a_vld  = a_vld_reg;
    assign status.a_last = a_tag_reg.last;

endmodule

// ===== design/box_filter_texture_downsampler.sv =====
// ----------------------------------------------------------------------------
// box_filter_texture_downsampler
// Raster-order box filter that reduces an image by 1, 2 or 4 per axis.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock unless a block result waits on a stalled
// output, and gives one reduced pixel per clock at most. The last pixel of a
// block passes the accumulation register, then the result register. The rate
// is set by the single read-modify-write of the line store (8192 x 48 bits,
// one write and one registered read port) per pixel, with a bypass for the
// entry written in the same cycle. The line store needs no clearing pass
// after reset: the first pixel of every block writes its entry. Any
// configuration write restarts the image at the top-left pixel; write configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
module box_filter_texture_downsampler import bfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_pix_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_pix_t              out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    px_tag_t     tag;
    acc_status_t status;
    logic        in_fire;

    assign in_fire = in_valid && in_ready;

    bfd_raster u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .tag       (tag)
    );

    bfd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .tag       (tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .status    (status)
    );

`ifndef SYNTHESIS
    // a block-final pixel waiting on a full, stalled result slot blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.a_vld && status.a_last && out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while block result cannot retire");

    // an empty accumulation stage never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !status.a_vld |-> in_ready)
        else $error("input stalled with empty accumulation stage");

    // an accepted transaction always lands in the accumulation stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> status.a_vld)
        else $error("accepted transaction lost");
`endif

endmodule
